// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the dirty word flush block, included by its top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("Same-cycle check failed.");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("Next-cycle check failed.");
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== src/fdwf_pkg.sv =====
// Package with the constants and codes of the dirty word flush block.
package fdwf_pkg;

    localparam int ROWS_DEF      = 64;
    localparam int WORDS_PER_ROW = 8;
    localparam int WORD_W        = 16;
    localparam int WIDX_W        = 3;
    localparam int ROW_IN_W      = 6;
    localparam int COL_W         = 7;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int FILL_W        = 8;

    localparam logic [WIDX_W-1:0] WORD_LAST = WIDX_W'(WORDS_PER_ROW - 1);

    localparam logic [2:0] KIND_PIXEL = 3'd0;
    localparam logic [2:0] KIND_ROW   = 3'd1;
    localparam logic [2:0] KIND_COL   = 3'd2;
    localparam logic [2:0] KIND_CLEAR = 3'd3;
    localparam logic [2:0] KIND_FLUSH = 3'd4;
    localparam logic [2:0] KIND_FORCE = 3'd5;

    localparam logic [1:0] OK_OFF  = 2'd0;
    localparam logic [1:0] OK_ADDR = 2'd1;
    localparam logic [1:0] OK_DATA = 2'd2;
    localparam logic [1:0] OK_ON   = 2'd3;

    localparam logic [PADDR_W-3:0] REG_FILL = 1'b0;

endpackage

// ===== src/framebuffer_dirty_word_flush.sv =====
// After reset a clearing pass zeroes both copies; busy stays high meanwhile.
// Pixel and column edits are bound by memory read-modify-write, a column edit once per row.
// A row fill and a clear write one word per cycle.
// A flush row compares each word, sends address and data per dirty word, then closes.
// Results leave at most one per cycle through a one-entry holding register and cannot stall.
// The last result appears in the first cycle that busy is low again.
module framebuffer_dirty_word_flush #(
    parameter int ROWS = fdwf_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    kind,
    input  logic [fdwf_pkg::ROW_IN_W-1:0] row,
    input  logic [fdwf_pkg::COL_W-1:0]    col,
    input  logic                          light,
    output logic                          result_valid,
    output logic [1:0]                    out_kind,
    output logic [4:0]                    vert_addr,
    output logic [3:0]                    horiz_addr,
    output logic [fdwf_pkg::WORD_W-1:0]   data_word,
    output logic                          last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fdwf_pkg::PADDR_W-1:0]  paddr,
    input  logic [fdwf_pkg::PDATA_W-1:0]  pwdata,
    output logic [fdwf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    import fdwf_pkg::*;
    `include "assert_macros.svh"

    localparam int DEPTH  = ROWS * WORDS_PER_ROW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(ROWS);
    localparam logic [ADDR_W-1:0]   CNT_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [ROW_IN_W-1:0] ROW_LAST = ROW_IN_W'(ROWS - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLEAR, S_FILL, S_PIX_RD, S_PIX_WR,
        S_FL_RD, S_FL_CMP, S_FL_OFF, S_FL_ADDR, S_FL_DATA, S_FL_END, S_FL_FIN
    } state_t;

    state_t                state_reg;
    logic [ADDR_W-1:0]     cnt_reg;
    logic [ROW_IN_W-1:0]   row_reg;
    logic [WIDX_W-1:0]     word_reg;
    logic [3:0]            pix_reg;
    logic                  light_reg;
    logic                  col_mode_reg;
    logic                  force_reg;
    logic                  paused_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [WORD_W-1:0]     data_reg;

    logic                  pend_valid_reg;
    logic [1:0]            pend_kind_reg;
    logic [4:0]            pend_vert_reg;
    logic [3:0]            pend_horiz_reg;
    logic [WORD_W-1:0]     pend_data_reg;

    logic                  strobe_reg;
    logic [1:0]            okind_reg;
    logic [4:0]            vert_reg;
    logic [3:0]            horiz_reg;
    logic [WORD_W-1:0]     dword_reg;
    logic                  last_reg;

    logic                  accept;
    logic                  flush_accept;
    logic [ROW_IN_W:0]     row_diff;
    logic [ROW_IN_W-1:0]   row_wrap;
    logic [ADDR_W-1:0]     word_addr;
    logic [WORD_W-1:0]     front_q;
    logic [WORD_W-1:0]     shadow_q;
    logic [WORD_W-1:0]     pix_mask;
    logic                  dirty;
    logic                  last_row;
    logic                  front_we;
    logic [ADDR_W-1:0]     front_waddr;
    logic [WORD_W-1:0]     front_wdata;
    logic                  shadow_we;
    logic [ADDR_W-1:0]     shadow_waddr;
    logic [WORD_W-1:0]     shadow_wdata;
    logic                  cfg_we;

    logic                  new_valid;
    logic [1:0]            new_kind;
    logic [4:0]            new_vert;
    logic [3:0]            new_horiz;
    logic [WORD_W-1:0]     new_data;

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign flush_accept = accept && (kind == KIND_FLUSH || kind == KIND_FORCE);
    assign row_diff     = {1'b0, row} - (ROW_IN_W + 1)'(ROWS);
    assign row_wrap     = row_diff[ROW_IN_W] ? row : row_diff[ROW_IN_W-1:0];

    assign word_addr = {row_reg[ROW_W-1:0], word_reg};
    assign pix_mask  = WORD_W'(16'h8000 >> pix_reg);
    assign dirty     = force_reg || (front_q != shadow_q);
    assign last_row  = (row_reg == ROW_LAST);

    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1:2] == REG_FILL);
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_FILL) ? PDATA_W'(fill_reg) : '0;

    always_comb
    begin
        front_we    = 1'b0;
        front_waddr = word_addr;
        front_wdata = '0;
        unique case (state_reg)
            S_INIT:
            begin
                front_we    = 1'b1;
                front_waddr = cnt_reg;
            end
            S_CLEAR:
            begin
                front_we    = 1'b1;
                front_waddr = cnt_reg;
                front_wdata = {fill_reg, fill_reg};
            end
            S_FILL:
            begin
                front_we    = 1'b1;
                front_wdata = light_reg ? '1 : '0;
            end
            S_PIX_WR:
            begin
                front_we    = 1'b1;
                front_wdata = light_reg ? (front_q | pix_mask) : (front_q & ~pix_mask);
            end
            default:
            begin
                front_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        shadow_we    = 1'b0;
        shadow_waddr = word_addr;
        shadow_wdata = front_q;
        if (state_reg == S_INIT)
        begin
            shadow_we    = 1'b1;
            shadow_waddr = cnt_reg;
            shadow_wdata = '0;
        end
        else if (state_reg == S_FL_CMP)
        begin
            shadow_we = dirty;
        end
    end

    always_comb
    begin
        new_valid = 1'b0;
        new_kind  = OK_OFF;
        new_vert  = '0;
        new_horiz = '0;
        new_data  = '0;
        unique case (state_reg)
            S_FL_OFF:
            begin
                new_valid = 1'b1;
            end
            S_FL_ADDR:
            begin
                new_valid = 1'b1;
                new_kind  = OK_ADDR;
                new_vert  = row_reg[4:0];
                // Rows of the lower half sit in the right half of the address space.
                new_horiz = {row_reg[5], word_reg};
            end
            S_FL_DATA:
            begin
                new_valid = 1'b1;
                new_kind  = OK_DATA;
                new_data  = data_reg;
            end
            S_FL_END:
            begin
                new_valid = last_row && paused_reg;
                new_kind  = OK_ON;
            end
            default:
            begin
                new_valid = 1'b0;
            end
        endcase
    end

    fdwf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_front (
        .clk   (clk),
        .we    (front_we),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .raddr (word_addr),
        .rdata (front_q)
    );

    fdwf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_shadow (
        .clk   (clk),
        .we    (shadow_we),
        .waddr (shadow_waddr),
        .wdata (shadow_wdata),
        .raddr (word_addr),
        .rdata (shadow_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            paused_reg     <= 1'b0;
            fill_reg       <= '0;
            data_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_kind_reg  <= OK_OFF;
            pend_vert_reg  <= '0;
            pend_horiz_reg <= '0;
            pend_data_reg  <= '0;
            strobe_reg     <= 1'b0;
            okind_reg      <= OK_OFF;
            vert_reg       <= '0;
            horiz_reg      <= '0;
            dword_reg      <= '0;
            last_reg       <= 1'b0;
            row_reg        <= '0;
            word_reg       <= '0;
            pix_reg        <= '0;
            light_reg      <= 1'b0;
            col_mode_reg   <= 1'b0;
            force_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fill_reg <= pwdata[FILL_W-1:0];
            end

            if (new_valid)
            begin
                strobe_reg     <= pend_valid_reg;
                last_reg       <= 1'b0;
                okind_reg      <= pend_kind_reg;
                vert_reg       <= pend_vert_reg;
                horiz_reg      <= pend_horiz_reg;
                dword_reg      <= pend_data_reg;
                pend_valid_reg <= 1'b1;
                pend_kind_reg  <= new_kind;
                pend_vert_reg  <= new_vert;
                pend_horiz_reg <= new_horiz;
                pend_data_reg  <= new_data;
            end
            else if (state_reg == S_FL_FIN)
            begin
                strobe_reg     <= pend_valid_reg;
                last_reg       <= pend_valid_reg;
                okind_reg      <= pend_kind_reg;
                vert_reg       <= pend_vert_reg;
                horiz_reg      <= pend_horiz_reg;
                dword_reg      <= pend_data_reg;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                strobe_reg <= 1'b0;
                last_reg   <= 1'b0;
            end

            unique case (state_reg)
                S_INIT, S_CLEAR:
                begin
                    cnt_reg <= (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pix_reg      <= col[3:0];
                        light_reg    <= light;
                        col_mode_reg <= (kind == KIND_COL);
                        force_reg    <= (kind == KIND_FORCE);
                        unique case (kind)
                            KIND_PIXEL:
                            begin
                                row_reg   <= row_wrap;
                                word_reg  <= col[COL_W-1:4];
                                state_reg <= S_PIX_RD;
                            end
                            KIND_COL:
                            begin
                                row_reg   <= '0;
                                word_reg  <= col[COL_W-1:4];
                                state_reg <= S_PIX_RD;
                            end
                            KIND_ROW:
                            begin
                                row_reg   <= row_wrap;
                                word_reg  <= '0;
                                state_reg <= S_FILL;
                            end
                            KIND_CLEAR:
                            begin
                                cnt_reg   <= '0;
                                state_reg <= S_CLEAR;
                            end
                            KIND_FLUSH, KIND_FORCE:
                            begin
                                row_reg   <= row_wrap;
                                word_reg  <= '0;
                                state_reg <= S_FL_RD;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_FILL:
                begin
                    word_reg <= word_reg + 1'b1;
                    if (word_reg == WORD_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_PIX_RD:
                begin
                    state_reg <= S_PIX_WR;
                end
                S_PIX_WR:
                begin
                    if (col_mode_reg && !last_row)
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= S_PIX_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_FL_RD:
                begin
                    state_reg <= S_FL_CMP;
                end
                S_FL_CMP:
                begin
                    data_reg <= front_q;
                    if (dirty)
                    begin
                        state_reg <= paused_reg ? S_FL_ADDR : S_FL_OFF;
                    end
                    else if (word_reg == WORD_LAST)
                    begin
                        state_reg <= S_FL_END;
                    end
                    else
                    begin
                        word_reg  <= word_reg + 1'b1;
                        state_reg <= S_FL_RD;
                    end
                end
                S_FL_OFF:
                begin
                    paused_reg <= 1'b1;
                    state_reg  <= S_FL_ADDR;
                end
                S_FL_ADDR:
                begin
                    state_reg <= S_FL_DATA;
                end
                S_FL_DATA:
                begin
                    if (word_reg == WORD_LAST)
                    begin
                        state_reg <= S_FL_END;
                    end
                    else
                    begin
                        word_reg  <= word_reg + 1'b1;
                        state_reg <= S_FL_RD;
                    end
                end
                S_FL_END:
                begin
                    if (last_row && paused_reg)
                    begin
                        paused_reg <= 1'b0;
                    end
                    state_reg <= S_FL_FIN;
                end
                S_FL_FIN:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = strobe_reg;
    assign out_kind     = okind_reg;
    assign vert_addr    = vert_reg;
    assign horiz_addr   = horiz_reg;
    assign data_word    = dword_reg;
    assign last         = last_reg;

    `ASSERT_IMPLY(a_last_ends_item, clk, rst_n, result_valid && last, state_reg == S_IDLE)
    `ASSERT_IMPLY(a_pend_in_flush, clk, rst_n, pend_valid_reg, busy && state_reg != S_INIT)
    `ASSERT_NEXT(a_flush_starts, clk, rst_n, flush_accept, state_reg == S_FL_RD && word_reg == '0)
    `ASSERT_IMPLY(a_no_result_idle, clk, rst_n, new_valid, busy)

endmodule

// ===== src/fdwf_ram.sv =====
// Single write port, single registered read port word memory.
module fdwf_ram #(
    parameter int WIDTH = fdwf_pkg::WORD_W,
    parameter int DEPTH = fdwf_pkg::ROWS_DEF * fdwf_pkg::WORDS_PER_ROW
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== bench/fdwf_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts the LCD command stream of the flush block, compares each result and checks fill reads.
module fdwf_checker
    import fdwf_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [2:0]          kind,
    input  logic [ROW_IN_W-1:0] row,
    input  logic [COL_W-1:0]    col,
    input  logic                light,
    input  logic                result_valid,
    input  logic [1:0]          out_kind,
    input  logic [4:0]          vert_addr,
    input  logic [3:0]          horiz_addr,
    input  logic [WORD_W-1:0]   data_word,
    input  logic                last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic [PDATA_W-1:0]  prdata,
    input  logic                pready,
    output int                  fail_count,
    output int                  pending
);

    localparam int HALF_ROWS = 32;
    localparam int FB_WORDS  = ROWS * WORDS_PER_ROW;
    localparam logic [PADDR_W-1:0] FILL_ADDR = {REG_FILL, 2'b00};

    typedef struct packed {
        logic [1:0]        kind;
        logic [4:0]        vert;
        logic [3:0]        horiz;
        logic [WORD_W-1:0] data;
        logic              last;
    } lcd_cmd_t;

    logic [WORD_W-1:0] front_fb [FB_WORDS];
    logic [WORD_W-1:0] shadow_fb [FB_WORDS];
    logic              paused;
    logic [FILL_W-1:0] fill_byte;
    lcd_cmd_t          lcd_cmds [$];

    function automatic lcd_cmd_t make_cmd(input logic [1:0] k, input logic [4:0] v,
                                          input logic [3:0] h, input logic [WORD_W-1:0] d);
        lcd_cmd_t c;
        c.kind  = k;
        c.vert  = v;
        c.horiz = h;
        c.data  = d;
        c.last  = 1'b0;
        return c;
    endfunction

    task automatic paint_pixel(input int r, input logic [COL_W-1:0] c, input logic on);
        int                idx;
        logic [WORD_W-1:0] mask;
        idx  = r * WORDS_PER_ROW + int'(c[COL_W-1:4]);
        mask = 16'h8000 >> c[3:0];
        if (on)
            front_fb[idx] = front_fb[idx] | mask;
        else
            front_fb[idx] = front_fb[idx] & ~mask;
    endtask

    task automatic flush_row(input logic [2:0] k, input int r);
        lcd_cmd_t batch [$];
        lcd_cmd_t c;
        int       idx;
        for (int w = 0; w < WORDS_PER_ROW; w++)
        begin
            idx = r * WORDS_PER_ROW + w;
            if (k == KIND_FORCE || front_fb[idx] != shadow_fb[idx])
            begin
                if (!paused)
                begin
                    batch.push_back(make_cmd(OK_OFF, 5'd0, 4'd0, '0));
                    paused = 1'b1;
                end
                batch.push_back(make_cmd(OK_ADDR, 5'(r % HALF_ROWS),
                                         4'(w + (r >= HALF_ROWS ? 8 : 0)), '0));
                batch.push_back(make_cmd(OK_DATA, 5'd0, 4'd0, front_fb[idx]));
                shadow_fb[idx] = front_fb[idx];
            end
        end
        if (r == ROWS - 1 && paused)
        begin
            batch.push_back(make_cmd(OK_ON, 5'd0, 4'd0, '0));
            paused = 1'b0;
        end
        for (int i = 0; i < batch.size(); i++)
        begin
            c      = batch[i];
            c.last = (i == batch.size() - 1);
            lcd_cmds.push_back(c);
        end
    endtask

    task automatic apply_item(input logic [2:0] k, input logic [ROW_IN_W-1:0] r_in,
                              input logic [COL_W-1:0] c, input logic on);
        int r;
        r = int'(r_in) % ROWS;
        case (k)
            KIND_PIXEL: paint_pixel(r, c, on);
            KIND_ROW:
                for (int w = 0; w < WORDS_PER_ROW; w++)
                    front_fb[r * WORDS_PER_ROW + w] = on ? 16'hffff : 16'h0000;
            KIND_COL:
                for (int i = 0; i < ROWS; i++)
                    paint_pixel(i, c, on);
            KIND_CLEAR:
                for (int i = 0; i < FB_WORDS; i++)
                    front_fb[i] = {fill_byte, fill_byte};
            KIND_FLUSH, KIND_FORCE: flush_row(k, r);
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lcd_cmd_t want;
        lcd_cmd_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < FB_WORDS; i++)
            begin
                front_fb[i]  = '0;
                shadow_fb[i] = '0;
            end
            paused     = 1'b0;
            fill_byte  = '0;
            fail_count = 0;
            lcd_cmds.delete();
        end
        else
        begin
            if (result_valid)
            begin
                got = {out_kind, vert_addr, horiz_addr, data_word, last};
                if (lcd_cmds.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: expected no result, got kind=%0d vert=%0d horiz=%0d",
                             $time, got.kind, got.vert, got.horiz,
                             " data=%h last=%b", got.data, got.last);
                end
                else
                begin
                    want = lcd_cmds.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        $display("%0t: expected kind=%0d vert=%0d horiz=%0d data=%h last=%b,",
                                 $time, want.kind, want.vert, want.horiz, want.data,
                                 want.last,
                                 " got kind=%0d vert=%0d horiz=%0d data=%h last=%b",
                                 got.kind, got.vert, got.horiz, got.data, got.last);
                    end
                end
            end
            if (psel && penable && pready && paddr == FILL_ADDR)
            begin
                if (pwrite)
                begin
                    fill_byte = pwdata[FILL_W-1:0];
                end
                else if (prdata !== PDATA_W'(fill_byte))
                begin
                    fail_count++;
                    $display("%0t: fill register read: expected %h, got %h",
                             $time, PDATA_W'(fill_byte), prdata);
                end
            end
            if (start && !busy)
                apply_item(kind, row, col, light);
        end
        pending = lcd_cmds.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench that drives edits, row flushes and fill register writes and reads into the block.
module tb;
    import fdwf_pkg::*;

    localparam int ROWS        = ROWS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 21;
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam logic [PADDR_W-1:0] FILL_ADDR = {REG_FILL, 2'b00};

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [2:0]          kind;
    logic [ROW_IN_W-1:0] row;
    logic [COL_W-1:0]    col;
    logic                light;
    logic                result_valid;
    logic [1:0]          out_kind;
    logic [4:0]          vert_addr;
    logic [3:0]          horiz_addr;
    logic [WORD_W-1:0]   data_word;
    logic                last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;
    int                  cycle_count;
    int                  next_row;
    int                  made;
    int                  pick;
    bit                  gaps_on;

    framebuffer_dirty_word_flush #(.ROWS(ROWS)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .row(row), .col(col), .light(light),
        .result_valid(result_valid), .out_kind(out_kind), .vert_addr(vert_addr),
        .horiz_addr(horiz_addr), .data_word(data_word), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    fdwf_checker #(.ROWS(ROWS)) check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .row(row), .col(col), .light(light),
        .result_valid(result_valid), .out_kind(out_kind), .vert_addr(vert_addr),
        .horiz_addr(horiz_addr), .data_word(data_word), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic send(input logic [2:0] k, input int r, input logic [COL_W-1:0] c,
                        input logic on);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        start <= 1'b1;
        kind  <= k;
        row   <= ROW_IN_W'(r);
        col   <= c;
        light <= on;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0 || busy);
        repeat (16) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= FILL_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_fill(input logic [FILL_W-1:0] value);
        settle();
        apb_access(1'b1, PDATA_W'(value));
        apb_access(1'b0, '0);
        @(negedge clk);
    endtask

    task automatic advance_row();
        int step;
        step = int'($urandom_range(2, 12));
        if (next_row == ROWS - 1)
            next_row = 0;
        else if ($urandom_range(0, 9) == 0)
            next_row = (next_row + step > ROWS - 1) ? ROWS - 1 : next_row + step;
        else
            next_row++;
    endtask

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        start    = 1'b0;
        kind     = KIND_PIXEL;
        row      = '0;
        col      = '0;
        light    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        gaps_on  = 1'b1;
        next_row = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        write_fill(8'h5a);
        send(KIND_FLUSH, 0, 7'd3, 1'b0);
        send(KIND_FLUSH, ROWS - 1, 7'd100, 1'b1);
        send(KIND_PIXEL, 0, 7'd0, 1'b1);
        send(KIND_PIXEL, 40, 7'd127, 1'b1);
        send(KIND_PIXEL, 40, 7'd126, 1'b1);
        send(KIND_PIXEL, 40, 7'd126, 1'b0);
        send(KIND_ROW, ROWS - 1, 7'd0, 1'b1);
        send(KIND_COL, 0, 7'd77, 1'b1);
        send(KIND_FLUSH, 0, 7'd127, 1'b1);
        send(KIND_FLUSH, 40, 7'd0, 1'b0);
        send(KIND_FORCE, 5, 7'd85, 1'b1);
        send(KIND_SPARE_LO, 12, 7'd42, 1'b1);
        send(KIND_SPARE_HI, 63, 7'd127, 1'b0);
        send(KIND_FLUSH, ROWS - 1, 7'd0, 1'b0);
        send(KIND_FLUSH, ROWS - 1, 7'd0, 1'b1);
        send(KIND_CLEAR, 0, 7'd0, 1'b0);
        send(KIND_ROW, 10, 7'd0, 1'b0);
        send(KIND_COL, 0, 7'd0, 1'b0);
        send(KIND_FORCE, ROWS - 1, 7'd0, 1'b0);
        send(KIND_FLUSH, 32, 7'd0, 1'b1);
        send(KIND_FLUSH, 31, 7'd0, 1'b0);
        send(KIND_FLUSH, ROWS - 1, 7'd0, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       write_fill(8'hff);
                2:       write_fill(8'h00);
                default: write_fill(FILL_W'($urandom));
            endcase
            gaps_on = (ph != PHASES - 1);
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 52)
                begin
                    send(($urandom_range(0, 4) == 0) ? KIND_FORCE : KIND_FLUSH, next_row,
                         COL_W'($urandom), 1'($urandom));
                    advance_row();
                end
                else if (pick < 66)
                begin
                    send(KIND_PIXEL, (next_row + $urandom_range(0, 3)) % ROWS,
                         COL_W'($urandom), 1'($urandom));
                end
                else if (pick < 72)
                begin
                    send(KIND_ROW, $urandom_range(0, ROWS - 1), COL_W'($urandom),
                         1'($urandom));
                end
                else if (pick < 78)
                begin
                    send(KIND_COL, $urandom_range(0, ROWS - 1), COL_W'($urandom),
                         1'($urandom));
                end
                else if (pick < 81)
                begin
                    send(KIND_CLEAR, $urandom_range(0, ROWS - 1), COL_W'($urandom),
                         1'($urandom));
                end
                else if (pick < 86)
                begin
                    send(($urandom_range(0, 1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI,
                         $urandom_range(0, ROWS - 1), COL_W'($urandom), 1'($urandom));
                    made--;
                end
                else
                begin
                    send(($urandom_range(0, 3) == 0) ? KIND_FORCE : KIND_FLUSH,
                         $urandom_range(0, ROWS - 1), COL_W'($urandom), 1'($urandom));
                end
                made++;
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            if (pending != 0)
                $display("%0t: %0d expected results never arrived", $time, pending);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
